// ===== rtl/ledag_pkg.sv =====
// ----------------------------------------------------------------------------
// ledag_pkg
// shared widths, defaults, register indexes, status codes and beat types for
// the led drive auto-gain and lead detect block
// ----------------------------------------------------------------------------
package ledag_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int DAC_W      = 10;
  localparam int DEB_W      = 7;
  localparam int BAND_W     = 10;
  localparam int LEAD_W     = 2;
  localparam int ADJ_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int BAND_MAX   = (1 << BAND_W) - 1;
  localparam int DAC_MAX    = (1 << DAC_W) - 1;

  localparam int WINDOW_DEF       = 50;
  localparam int ROUGH_DELAY_DEF  = 30;
  localparam int FINE_DELAY_DEF   = 30;
  localparam int ROUGH_STEP_DEF   = 5;
  localparam int STABLE_COUNT_DEF = 3;

  localparam logic [SAMPLE_W-1:0] FINGER_OFF_RST = 12'd100;
  localparam logic [SAMPLE_W-1:0] PROBE_OFF_RST  = 12'd2000;
  localparam logic [DEB_W-1:0]    DEBOUNCE_RST   = 7'd100;
  localparam logic [SAMPLE_W-1:0] IR_CENTER_RST  = 12'd1350;
  localparam logic [SAMPLE_W-1:0] RED_CENTER_RST = 12'd1500;
  localparam logic [BAND_W-1:0]   FINE_BAND_RST  = 10'd150;
  localparam logic [DAC_W-1:0]    DAC_MAX_RST    = 10'd300;
  localparam logic [DAC_W-1:0]    DAC_MIN_RST    = 10'd20;

  localparam logic [CFG_IDX_W-1:0] CFG_FINGER_OFF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_OFF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IR_CENTER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_CENTER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FINE_BAND  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DAC_MAX    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DAC_MIN    = 3'd7;

  localparam logic [LEAD_W-1:0] LEAD_PROBE_OFF  = 2'd0;
  localparam logic [LEAD_W-1:0] LEAD_FINGER_OFF = 2'd1;
  localparam logic [LEAD_W-1:0] LEAD_FINGER_ON  = 2'd2;

  localparam logic [ADJ_W-1:0] ADJ_ROUGH_INIT = 3'd0;
  localparam logic [ADJ_W-1:0] ADJ_ROUGH_BUSY = 3'd1;
  localparam logic [ADJ_W-1:0] ADJ_FINE_INIT  = 3'd2;
  localparam logic [ADJ_W-1:0] ADJ_FINE_BUSY  = 3'd3;
  localparam logic [ADJ_W-1:0] ADJ_FINE_DONE  = 3'd4;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red_sample;
    logic [SAMPLE_W-1:0] ir_sample;
  } ledag_sample_t;

  typedef struct packed {
    logic [DAC_W-1:0]  dac_level;
    logic [LEAD_W-1:0] lead_status;
    logic              lead_changed;
    logic [ADJ_W-1:0]  adjust_status;
    logic              adjust_changed;
  } ledag_result_t;

endpackage

// ===== rtl/ledag_window.sv =====
// ----------------------------------------------------------------------------
// ledag_window
// sliding window sum of one channel: sample memory with prefetched read of
// the oldest entry, per-entry valid bits, running sum
// ----------------------------------------------------------------------------
module ledag_window #(
  parameter int WINDOW = ledag_pkg::WINDOW_DEF,
  parameter int SUM_W  = $clog2(WINDOW * ledag_pkg::SAMPLE_MAX + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          commit,
  input  logic [ledag_pkg::SAMPLE_W-1:0] sample,
  output logic [SUM_W-1:0]              sum_next
);

  localparam int POS_W = $clog2(WINDOW);

  logic [ledag_pkg::SAMPLE_W-1:0] mem [WINDOW];
  logic [ledag_pkg::SAMPLE_W-1:0] rd_data;
  logic [ledag_pkg::SAMPLE_W-1:0] oldest;
  logic [WINDOW-1:0]              filled;
  logic [POS_W-1:0]               pos;
  logic [POS_W-1:0]               pos_next;
  logic [POS_W-1:0]               rd_addr;
  logic [SUM_W-1:0]               sum;

  assign pos_next = (pos == POS_W'(WINDOW - 1)) ? '0 : pos + 1'b1;
  assign rd_addr  = commit ? pos_next : pos;
  assign oldest   = filled[pos] ? rd_data : '0;
  assign sum_next = sum - SUM_W'(oldest) + SUM_W'(sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      filled <= '0;
      sum    <= '0;
    end else if (commit) begin
      pos         <= pos_next;
      filled[pos] <= 1'b1;
      sum         <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      mem[pos] <= sample;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/led_drive_autogain_lead_detect_top.sv =====
// ----------------------------------------------------------------------------
// led_drive_autogain_lead_detect_top
// lead and finger detection with debounce, windowed averages per channel and
// rough then fine led drive level control
// the input stage registers a sample beat, the result buffer its result beat
// throughput: one sample beat per cycle when not stalled; the window memory
// read is prefetched for the next position so its single read port never
// limits the rate; a two-entry result buffer keeps sample_stall registered
// reset: synchronous; registers return to defaults, window valid bits clear at
// once, no clearing pass; drive level restarts at the default minimum
// ----------------------------------------------------------------------------
module led_drive_autogain_lead_detect_top #(
  parameter int WINDOW       = ledag_pkg::WINDOW_DEF,
  parameter int ROUGH_DELAY  = ledag_pkg::ROUGH_DELAY_DEF,
  parameter int FINE_DELAY   = ledag_pkg::FINE_DELAY_DEF,
  parameter int ROUGH_STEP   = ledag_pkg::ROUGH_STEP_DEF,
  parameter int STABLE_COUNT = ledag_pkg::STABLE_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  ledag_pkg::ledag_sample_t         sample,
  output logic                             result_valid,
  input  logic                             result_stall,
  output ledag_pkg::ledag_result_t         result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ledag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ledag_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SW     = ledag_pkg::SAMPLE_W;
  localparam int DW     = ledag_pkg::DAC_W;
  localparam int SUM_W  = $clog2(WINDOW * ledag_pkg::SAMPLE_MAX + 1);
  localparam int PROD_W = $clog2((ledag_pkg::SAMPLE_MAX + ledag_pkg::BAND_MAX) * WINDOW + 1);
  localparam int RUN_W  = $clog2(STABLE_COUNT + 1);
  localparam int RDLY_W = $clog2(ROUGH_DELAY + 1);
  localparam int FDLY_W = $clog2(FINE_DELAY + 1);
  localparam int STEP_W = $clog2(ledag_pkg::DAC_MAX + ROUGH_STEP + 1);
  localparam int DEB_W  = ledag_pkg::DEB_W;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_UNSTABLE,
    ST_STABLE
  } stab_t;

  // configuration
  logic [SW-1:0]                   finger_off_level;
  logic [SW-1:0]                   probe_off_level;
  logic [DEB_W-1:0]                debounce_count;
  logic [SW-1:0]                   ir_center;
  logic [SW-1:0]                   red_center;
  logic [ledag_pkg::BAND_W-1:0]    fine_band;
  logic [DW-1:0]                   dac_max;
  logic [DW-1:0]                   dac_min;

  // pipeline and result buffer
  ledag_pkg::ledag_sample_t        s1_data;
  logic                            s1_valid;
  ledag_pkg::ledag_result_t        res_data;
  ledag_pkg::ledag_result_t        skid_data;
  ledag_pkg::ledag_result_t        res_new;
  logic                            res_valid;
  logic                            skid_valid;
  logic                            accept;
  logic                            commit;
  logic                            res_take;

  // control state
  logic                            probe_on;
  logic                            finger_on;
  logic [DEB_W-1:0]                probe_off_run;
  logic [DEB_W-1:0]                probe_on_run;
  logic [DEB_W-1:0]                finger_off_run;
  logic [DEB_W-1:0]                finger_on_run;
  stab_t                           rough_state;
  logic [RUN_W-1:0]                rough_stable_run;
  logic [RDLY_W-1:0]               rough_delay;
  stab_t                           fine_state;
  logic [FDLY_W-1:0]               fine_delay;
  logic [DW-1:0]                   drive_level;

  logic                            probe_on_next;
  logic                            finger_on_next;
  logic [DEB_W-1:0]                probe_off_run_next;
  logic [DEB_W-1:0]                probe_on_run_next;
  logic [DEB_W-1:0]                finger_off_run_next;
  logic [DEB_W-1:0]                finger_on_run_next;
  stab_t                           rough_state_next;
  logic [RUN_W-1:0]                rough_stable_run_next;
  logic [RDLY_W-1:0]               rough_delay_next;
  stab_t                           fine_state_next;
  logic [FDLY_W-1:0]               fine_delay_next;
  logic [DW-1:0]                   drive_level_next;
  logic                            lead_flip;
  logic                            adj_flip;

  // window sums and limits
  logic [SUM_W-1:0]                ir_sum_next;
  logic [SUM_W-1:0]                red_sum_next;
  logic [PROD_W-1:0]               ir_sum_ext;
  logic [PROD_W-1:0]               red_sum_ext;
  logic [SW:0]                     ir_lo;
  logic [SW:0]                     red_lo;
  logic [SW:0]                     ir_hi;
  logic [SW:0]                     red_hi;
  logic                            rough_ok;
  logic                            fine_low;
  logic                            fine_high;
  logic [SW-1:0]                   red_s;
  logic [SW-1:0]                   ir_s;

  assign cfg_ready    = 1'b1;
  assign sample_stall = s1_valid & skid_valid;
  assign accept       = sample_valid & ~sample_stall;
  assign commit       = s1_valid & ~skid_valid;
  assign res_take     = res_valid & ~result_stall;
  assign result_valid = res_valid;
  assign result       = res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      finger_off_level <= ledag_pkg::FINGER_OFF_RST;
      probe_off_level  <= ledag_pkg::PROBE_OFF_RST;
      debounce_count   <= ledag_pkg::DEBOUNCE_RST;
      ir_center        <= ledag_pkg::IR_CENTER_RST;
      red_center       <= ledag_pkg::RED_CENTER_RST;
      fine_band        <= ledag_pkg::FINE_BAND_RST;
      dac_max          <= ledag_pkg::DAC_MAX_RST;
      dac_min          <= ledag_pkg::DAC_MIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ledag_pkg::CFG_FINGER_OFF: finger_off_level <= cfg_data[SW-1:0];
        ledag_pkg::CFG_PROBE_OFF:  probe_off_level  <= cfg_data[SW-1:0];
        ledag_pkg::CFG_DEBOUNCE:   debounce_count   <= cfg_data[DEB_W-1:0];
        ledag_pkg::CFG_IR_CENTER:  ir_center        <= cfg_data[SW-1:0];
        ledag_pkg::CFG_RED_CENTER: red_center       <= cfg_data[SW-1:0];
        ledag_pkg::CFG_FINE_BAND:  fine_band        <= cfg_data[ledag_pkg::BAND_W-1:0];
        ledag_pkg::CFG_DAC_MAX:    dac_max          <= cfg_data[DW-1:0];
        ledag_pkg::CFG_DAC_MIN:    dac_min          <= cfg_data[DW-1:0];
      endcase
    end
  end

  assign red_s = s1_data.red_sample;
  assign ir_s  = s1_data.ir_sample;

  ledag_window #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_ir_window (
    .clk      (clk),
    .rst      (rst),
    .commit   (commit),
    .sample   (ir_s),
    .sum_next (ir_sum_next)
  );

  ledag_window #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_red_window (
    .clk      (clk),
    .rst      (rst),
    .commit   (commit),
    .sample   (red_s),
    .sum_next (red_sum_next)
  );

  // window sums against center lines scaled by the window length
  assign ir_sum_ext  = PROD_W'(ir_sum_next);
  assign red_sum_ext = PROD_W'(red_sum_next);
  assign ir_lo  = {1'b0, ir_center} - (SW + 1)'(fine_band);
  assign red_lo = {1'b0, red_center} - (SW + 1)'(fine_band);
  assign ir_hi  = {1'b0, ir_center} + (SW + 1)'(fine_band);
  assign red_hi = {1'b0, red_center} + (SW + 1)'(fine_band);

  assign rough_ok =
    (ir_sum_ext <= PROD_W'(ir_center) * PROD_W'(WINDOW)) &&
    (red_sum_ext <= PROD_W'(red_center) * PROD_W'(WINDOW));

  // negative low edge never matches
  assign fine_low =
    (!ir_lo[SW] && (ir_sum_ext <= PROD_W'(ir_lo[SW-1:0]) * PROD_W'(WINDOW))) ||
    (!red_lo[SW] && (red_sum_ext <= PROD_W'(red_lo[SW-1:0]) * PROD_W'(WINDOW)));
  assign fine_high =
    (ir_sum_ext >= PROD_W'(ir_hi) * PROD_W'(WINDOW)) ||
    (red_sum_ext >= PROD_W'(red_hi) * PROD_W'(WINDOW));

  // probe and finger debounce
  always_comb begin
    logic [DEB_W:0] run_inc;
    run_inc             = '0;
    probe_on_next       = probe_on;
    finger_on_next      = finger_on;
    probe_off_run_next  = probe_off_run;
    probe_on_run_next   = probe_on_run;
    finger_off_run_next = finger_off_run;
    finger_on_run_next  = finger_on_run;
    lead_flip           = 1'b0;

    if (probe_on) begin
      if (red_s >= probe_off_level || ir_s >= probe_off_level) begin
        probe_on_run_next = '0;
        run_inc = {1'b0, probe_off_run} + 1'b1;
        if (run_inc >= {1'b0, debounce_count}) begin
          probe_on_next      = 1'b0;
          lead_flip          = 1'b1;
          probe_off_run_next = '0;
        end else begin
          probe_off_run_next = run_inc[DEB_W-1:0];
        end
      end else begin
        probe_off_run_next = '0;
      end
    end else begin
      if (red_s < probe_off_level || ir_s < probe_off_level) begin
        run_inc = {1'b0, probe_on_run} + 1'b1;
        if (run_inc >= {1'b0, debounce_count}) begin
          probe_on_next     = 1'b1;
          lead_flip         = 1'b1;
          probe_on_run_next = '0;
        end else begin
          probe_on_run_next = run_inc[DEB_W-1:0];
        end
      end else begin
        probe_on_run_next = '0;
      end
    end

    if (finger_on) begin
      if (red_s <= finger_off_level || ir_s <= finger_off_level) begin
        finger_on_run_next = '0;
        run_inc = {1'b0, finger_off_run} + 1'b1;
        if (run_inc >= {1'b0, debounce_count}) begin
          finger_on_next      = 1'b0;
          lead_flip           = 1'b1;
          finger_off_run_next = '0;
        end else begin
          finger_off_run_next = run_inc[DEB_W-1:0];
        end
      end else begin
        finger_off_run_next = '0;
      end
    end else begin
      if (red_s > finger_off_level || ir_s > finger_off_level) begin
        run_inc = {1'b0, finger_on_run} + 1'b1;
        if (run_inc >= {1'b0, debounce_count}) begin
          finger_on_next     = 1'b1;
          lead_flip          = 1'b1;
          finger_on_run_next = '0;
        end else begin
          finger_on_run_next = run_inc[DEB_W-1:0];
        end
      end else begin
        finger_on_run_next = '0;
      end
    end
  end

  // rough then fine level control
  always_comb begin
    logic [RUN_W-1:0]  run_inc;
    logic [RDLY_W-1:0] rdly_inc;
    logic [FDLY_W-1:0] fdly_inc;
    run_inc               = '0;
    rdly_inc              = '0;
    fdly_inc              = '0;
    rough_state_next      = rough_state;
    rough_stable_run_next = rough_stable_run;
    rough_delay_next      = rough_delay;
    fine_state_next       = fine_state;
    fine_delay_next       = fine_delay;
    drive_level_next      = drive_level;
    adj_flip              = 1'b0;

    if (probe_on_next && finger_on_next) begin
      if (rough_ok) begin
        run_inc = rough_stable_run + 1'b1;
        if (run_inc >= RUN_W'(STABLE_COUNT)) begin
          rough_stable_run_next = '0;
          if (rough_state != ST_STABLE) begin
            rough_state_next = ST_STABLE;
            adj_flip         = 1'b1;
          end
        end else begin
          rough_stable_run_next = run_inc;
        end
      end else begin
        rough_stable_run_next = '0;
        if (rough_state != ST_UNSTABLE) begin
          rough_state_next = ST_UNSTABLE;
          adj_flip         = 1'b1;
        end
      end
      if (rough_state_next == ST_UNSTABLE) begin
        rdly_inc = rough_delay + 1'b1;
        if (rdly_inc >= RDLY_W'(ROUGH_DELAY)) begin
          rough_delay_next = '0;
          if (STEP_W'(drive_level) + STEP_W'(ROUGH_STEP) <= STEP_W'(dac_max)) begin
            drive_level_next = DW'(STEP_W'(drive_level) + STEP_W'(ROUGH_STEP));
          end else begin
            drive_level_next      = dac_min;
            rough_state_next      = ST_INIT;
            rough_stable_run_next = '0;
            fine_state_next       = ST_INIT;
            rough_delay_next      = '0;
          end
        end else begin
          rough_delay_next = rdly_inc;
        end
      end
    end

    if (rough_state_next == ST_STABLE) begin
      if (fine_low || fine_high) begin
        if (fine_state != ST_UNSTABLE) begin
          fine_state_next = ST_UNSTABLE;
          adj_flip        = 1'b1;
        end
        fdly_inc = fine_delay + 1'b1;
        if (fdly_inc >= FDLY_W'(FINE_DELAY)) begin
          fine_delay_next = '0;
          if (fine_low && ({1'b0, drive_level} >= {1'b0, dac_min} + 1'b1)) begin
            drive_level_next = drive_level - 1'b1;
          end else if (!fine_low && ({1'b0, drive_level} + 1'b1 <= {1'b0, dac_max})) begin
            drive_level_next = drive_level + 1'b1;
          end else begin
            drive_level_next      = dac_min;
            rough_state_next      = ST_INIT;
            rough_stable_run_next = '0;
            fine_state_next       = ST_INIT;
            rough_delay_next      = '0;
          end
        end else begin
          fine_delay_next = fdly_inc;
        end
      end else if (fine_state != ST_STABLE) begin
        fine_state_next = ST_STABLE;
        adj_flip        = 1'b1;
      end
    end
  end

  always_comb begin
    res_new.dac_level      = drive_level_next;
    res_new.lead_changed   = lead_flip;
    res_new.adjust_changed = adj_flip;
    if (!probe_on_next) begin
      res_new.lead_status = ledag_pkg::LEAD_PROBE_OFF;
    end else if (!finger_on_next) begin
      res_new.lead_status = ledag_pkg::LEAD_FINGER_OFF;
    end else begin
      res_new.lead_status = ledag_pkg::LEAD_FINGER_ON;
    end
    if (rough_state_next == ST_UNSTABLE) begin
      res_new.adjust_status = ledag_pkg::ADJ_ROUGH_BUSY;
    end else if (rough_state_next != ST_STABLE) begin
      res_new.adjust_status = ledag_pkg::ADJ_ROUGH_INIT;
    end else if (fine_state_next == ST_UNSTABLE) begin
      res_new.adjust_status = ledag_pkg::ADJ_FINE_BUSY;
    end else if (fine_state_next == ST_STABLE) begin
      res_new.adjust_status = ledag_pkg::ADJ_FINE_DONE;
    end else begin
      res_new.adjust_status = ledag_pkg::ADJ_FINE_INIT;
    end
  end

  // state, input stage and result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      res_valid        <= 1'b0;
      skid_valid       <= 1'b0;
      probe_on         <= 1'b0;
      finger_on        <= 1'b0;
      probe_off_run    <= '0;
      probe_on_run     <= '0;
      finger_off_run   <= '0;
      finger_on_run    <= '0;
      rough_state      <= ST_INIT;
      rough_stable_run <= '0;
      rough_delay      <= '0;
      fine_state       <= ST_INIT;
      fine_delay       <= '0;
      drive_level      <= ledag_pkg::DAC_MIN_RST;
    end else begin
      if (accept) begin
        s1_data <= sample;
      end
      s1_valid <= accept | (s1_valid & ~commit);

      if (commit) begin
        probe_on         <= probe_on_next;
        finger_on        <= finger_on_next;
        probe_off_run    <= probe_off_run_next;
        probe_on_run     <= probe_on_run_next;
        finger_off_run   <= finger_off_run_next;
        finger_on_run    <= finger_on_run_next;
        rough_state      <= rough_state_next;
        rough_stable_run <= rough_stable_run_next;
        rough_delay      <= rough_delay_next;
        fine_state       <= fine_state_next;
        fine_delay       <= fine_delay_next;
        drive_level      <= drive_level_next;
      end

      if (skid_valid) begin
        if (res_take) begin
          res_data   <= skid_data;
          skid_valid <= 1'b0;
        end
      end else if (commit) begin
        if (!res_valid || res_take) begin
          res_data  <= res_new;
          res_valid <= 1'b1;
        end else begin
          skid_data  <= res_new;
          skid_valid <= 1'b1;
        end
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule
